[sv/ptc_pkg.sv]
// Shared constants and helper functions for the pressure/temperature compensation block.
package ptc_pkg;

  localparam int RawW = 20;
  localparam int CalW = 48;
  localparam int CfgIdxW = 2;
  localparam int WordW = 32;
  localparam int QueueDepthDflt = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TCAL = 2'd0,
    REG_PCAL_A = 2'd1,
    REG_PCAL_B = 2'd2,
    REG_PCAL_C = 2'd3
  } cfg_reg_t;

  // Front result: compensated temperature and the pressure-path operands
  typedef struct packed {
    logic [WordW-1:0] temp;
    logic [WordW-1:0] num;
    logic [WordW-1:0] den;
  } ptc_mid_t;

  // Sign-extend a 16-bit calibration word
  function automatic logic [WordW-1:0] sx16(input logic [15:0] w);
    sx16 = {{16{w[15]}}, w};
  endfunction

  // Arithmetic right shift of a 32-bit word
  function automatic logic [WordW-1:0] asr(input logic [WordW-1:0] x, input int n);
    asr = WordW'($signed(x) >>> n);
  endfunction

endpackage

[sv/ptc_front.sv]
// Front pipeline: temperature compensation and pressure divisor/dividend terms.
module ptc_front
  import ptc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_vld,
  input  logic [RawW-1:0] raw_t,
  input  logic [RawW-1:0] raw_p,
  input  logic [CalW-1:0] tcal,
  input  logic [CalW-1:0] pcal_a,
  input  logic [CalW-1:0] pcal_b,
  output logic            out_vld,
  output ptc_mid_t        out_mid
);

  localparam int Stg = 8;

  logic [Stg-1:0] vld_r;
  logic [WordW-1:0] t1, t2, t3, p1, p2, p3, p4, p5, p6;

  assign t1 = {16'd0, tcal[15:0]};
  assign t2 = sx16(tcal[31:16]);
  assign t3 = sx16(tcal[47:32]);
  assign p1 = {16'd0, pcal_a[15:0]};
  assign p2 = sx16(pcal_a[31:16]);
  assign p3 = sx16(pcal_a[47:32]);
  assign p4 = sx16(pcal_b[15:0]);
  assign p5 = sx16(pcal_b[31:16]);
  assign p6 = sx16(pcal_b[47:32]);

  // stage registers
  logic [RawW-1:0] rp1_r, rp2_r, rp3_r, rp4_r, rp5_r, rp6_r, rp7_r;
  logic [WordW-1:0] x1_r, d1_r;
  logic [WordW-1:0] a2_r, dd2_r;
  logic [WordW-1:0] a3_r, dt3_r;
  logic [WordW-1:0] fine4_r;
  logic [WordW-1:0] t5_r, v5_r, q5_r;
  logic [WordW-1:0] t6_r, b6_r, c6_r, e6_r;
  logic [WordW-1:0] t7_r, b7_r, s7_r;
  logic [WordW-1:0] t8_r, num8_r, den8_r;

  logic [WordW-1:0] d1, x1, b6, c6, s7, q5v, b7b, num;
  assign x1 = WordW'(raw_t >> 3) - (t1 << 1);
  assign d1 = WordW'(raw_t >> 4) - t1;
  assign q5v = asr(asr(fine4_r, 1) - 32'd64000, 2);
  assign b6 = asr(q5_r, 11) * p6 + ((v5_r * p5) << 1);
  assign c6 = asr(q5_r, 13);
  assign s7 = asr(asr(p3 * c6_r, 3) + asr(e6_r, 1), 18);
  assign b7b = asr(b6_r, 2) + (p4 << 16);
  assign num = ((32'd1048576 - WordW'(rp7_r)) - asr(b7_r, 12)) * 32'd3125;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[Stg-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // temperature products
      rp1_r <= raw_p; x1_r <= x1; d1_r <= d1;
      rp2_r <= rp1_r; a2_r <= asr(x1_r * t2, 11); dd2_r <= asr(d1_r * d1_r, 12);
      rp3_r <= rp2_r; a3_r <= a2_r; dt3_r <= asr(dd2_r * t3, 14);
      rp4_r <= rp3_r; fine4_r <= a3_r + dt3_r;
      // pressure terms
      rp5_r <= rp4_r; t5_r <= asr(fine4_r * 32'd5 + 32'd128, 8);
      v5_r <= asr(fine4_r, 1) - 32'd64000; q5_r <= q5v * q5v;
      rp6_r <= rp5_r; t6_r <= t5_r; b6_r <= b6; c6_r <= c6; e6_r <= p2 * v5_r;
      rp7_r <= rp6_r; t7_r <= t6_r; b7_r <= b7b; s7_r <= s7;
      t8_r <= t7_r; num8_r <= num; den8_r <= asr((32'd32768 + s7_r) * p1, 15);
    end
  end

  assign out_vld = vld_r[Stg-1];
  assign out_mid = '{temp: t8_r, num: num8_r, den: den8_r};

endmodule

[sv/ptc_queue.sv]
// Short FIFO between front and back pipelines.
module ptc_queue
  import ptc_pkg::*;
#(
  parameter int Depth = QueueDepthDflt,
  parameter int Width = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  logic [Width-1:0] wdata,
  input  logic             rd,
  output logic [Width-1:0] rdata,
  output logic             empty,
  output logic [$clog2(Depth+1)-1:0] count
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth+1);
  logic [Width-1:0] mem [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [CntW-1:0] cnt_r;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    inc = (p == AW'(Depth-1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= inc(wp_r);
      if (rd) rp_r <= inc(rp_r);
      cnt_r <= cnt_r + CntW'(wr) - CntW'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp_r] <= wdata;
  end

  assign rdata = mem[rp_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;

endmodule

[sv/ptc_back.sv]
// Back pipeline: pressure division and final pressure correction.
module ptc_back
  import ptc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_vld,
  input  ptc_mid_t        in_mid,
  input  logic [CalW-1:0] pcal_c,
  output logic            out_vld,
  output logic [WordW-1:0] out_temp,
  output logic [WordW-1:0] out_pres,
  output logic            out_dz
);

  // one quotient bit per stage, restoring division
  localparam int DivStg = WordW;
  localparam int Stg = DivStg + 5;

  logic [WordW-1:0] p7, p8, p9;
  assign p7 = sx16(pcal_c[15:0]);
  assign p8 = sx16(pcal_c[31:16]);
  assign p9 = sx16(pcal_c[47:32]);

  logic [Stg-1:0] vld_r;
  logic [WordW-1:0] tmp_r [Stg];
  logic dz_r [Stg];
  logic dbl_r [DivStg+1];
  logic [WordW-1:0] den_r [DivStg];
  logic [WordW-1:0] dvd_r [DivStg];
  logic [WordW-1:0] rem_r [DivStg];
  logic [WordW-1:0] quo_r [DivStg+1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[Stg-2:0], in_vld};
  end

  // division stages
  always_ff @(posedge clk) begin
    if (adv) begin
      tmp_r[0] <= in_mid.temp;
      dz_r[0] <= (in_mid.den == '0);
      dbl_r[0] <= ~in_mid.num[WordW-1];
      den_r[0] <= in_mid.den;
      dvd_r[0] <= in_mid.num[WordW-1] ? in_mid.num : (in_mid.num << 1);
      rem_r[0] <= '0;
      quo_r[0] <= '0;
      for (int i = 0; i < DivStg; i++) begin
        logic [WordW:0] sh;
        logic ge;
        sh = {rem_r[i], dvd_r[i][WordW-1-i]};
        ge = (sh >= {1'b0, den_r[i]});
        tmp_r[i+1] <= tmp_r[i];
        dz_r[i+1] <= dz_r[i];
        dbl_r[i+1] <= dbl_r[i];
        quo_r[i+1] <= ge ? (quo_r[i] | (32'd1 << (WordW-1-i))) : quo_r[i];
        if (i < DivStg-1) begin
          den_r[i+1] <= den_r[i];
          dvd_r[i+1] <= dvd_r[i];
          rem_r[i+1] <= ge ? WordW'(sh - {1'b0, den_r[i]}) : sh[WordW-1:0];
        end
      end
    end
  end

  // correction stages
  logic [WordW-1:0] pa_r, pb_r, pc_r, qa_r, ta_r, tb_r, tbd_r, fin_r;
  logic [WordW-1:0] pq, q3;
  assign pq = dbl_r[DivStg] ? quo_r[DivStg] : (quo_r[DivStg] << 1);
  assign q3 = pa_r >> 3;

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r <= pq;
      tmp_r[DivStg+1] <= tmp_r[DivStg]; dz_r[DivStg+1] <= dz_r[DivStg];
      qa_r <= q3 * q3;
      tb_r <= asr((pa_r >> 2) * p8, 13);
      pb_r <= pa_r;
      tmp_r[DivStg+2] <= tmp_r[DivStg+1]; dz_r[DivStg+2] <= dz_r[DivStg+1];
      ta_r <= asr(p9 * (qa_r >> 13), 12);
      tbd_r <= tb_r;
      pc_r <= pb_r;
      tmp_r[DivStg+3] <= tmp_r[DivStg+2]; dz_r[DivStg+3] <= dz_r[DivStg+2];
      fin_r <= dz_r[DivStg+3] ? '0 : pc_r + asr(ta_r + tbd_r + p7, 4);
      tmp_r[DivStg+4] <= tmp_r[DivStg+3]; dz_r[DivStg+4] <= dz_r[DivStg+3];
    end
  end

  assign out_vld = vld_r[Stg-1];
  assign out_temp = tmp_r[DivStg+4];
  assign out_pres = fin_r;
  assign out_dz = dz_r[DivStg+4];

endmodule

[sv/pressure_temperature_compensation_unit.sv]
// Top level of the pressure/temperature compensation block.
//   channel  | ports                                      | handshake
//   input    | in_raw_temperature, in_raw_pressure        | push / full
//   result   | out_temperature_centi, out_pressure_pascal,| pop / empty
//            | out_divide_by_zero                         |
//   config   | cfg_wr_en, cfg_index, cfg_data             | write strobe
// One item per cycle sustained while results are popped. A result passes
// through 8 front stages, the queue and 37 back stages (input capture,
// 32-stage divider, 4 correction stages).
// Synchronous active-low reset empties all pipelines and clears calibration.
// A waiting result holds the back pipeline; the queue absorbs front items,
// and once it is full with a front item waiting, the front holds and full rises.
module pressure_temperature_compensation_unit
  import ptc_pkg::*;
#(
  parameter int QueueDepth = QueueDepthDflt
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [RawW-1:0]  in_raw_temperature,
  input  logic [RawW-1:0]  in_raw_pressure,
  output logic             empty,
  input  logic             pop,
  output logic [WordW-1:0] out_temperature_centi,
  output logic [WordW-1:0] out_pressure_pascal,
  output logic             out_divide_by_zero,
  input  logic             cfg_wr_en,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CalW-1:0]  cfg_data
);

  localparam int CW = $clog2(QueueDepth+1);

  logic [CalW-1:0] tcal_r, pa_r, pb_r, pc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcal_r <= '0; pa_r <= '0; pb_r <= '0; pc_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_TCAL: tcal_r <= cfg_data;
        REG_PCAL_A: pa_r <= cfg_data;
        REG_PCAL_B: pb_r <= cfg_data;
        REG_PCAL_C: pc_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stall control: back holds on a waiting result, front holds on a full queue
  logic acc, adv_f, adv_b, f_vld, b_vld, q_wr, q_rd, q_empty, q_full;
  logic [CW-1:0] qcnt;
  ptc_mid_t f_mid, q_mid;

  assign q_full = (qcnt == CW'(QueueDepth));
  assign full = f_vld && q_full;
  assign acc = push && !full;
  assign adv_f = !full;
  assign q_wr = f_vld && !q_full;
  assign adv_b = !b_vld || pop;
  assign q_rd = !q_empty && adv_b;
  assign empty = !b_vld;

  ptc_front u_front (
    .clk, .rst_n, .adv(adv_f), .in_vld(acc), .raw_t(in_raw_temperature),
    .raw_p(in_raw_pressure), .tcal(tcal_r), .pcal_a(pa_r), .pcal_b(pb_r),
    .out_vld(f_vld), .out_mid(f_mid)
  );

  ptc_queue #(.Depth(QueueDepth), .Width($bits(ptc_mid_t))) u_q (
    .clk, .rst_n, .wr(q_wr), .wdata(f_mid), .rd(q_rd),
    .rdata(q_mid), .empty(q_empty), .count(qcnt)
  );

  ptc_back u_back (
    .clk, .rst_n, .adv(adv_b), .in_vld(q_rd), .in_mid(q_mid), .pcal_c(pc_r),
    .out_vld(b_vld), .out_temp(out_temperature_centi),
    .out_pres(out_pressure_pascal), .out_dz(out_divide_by_zero)
  );

endmodule
